// ===== rtl/cocktail_shaker_sorter_macros.svh =====
// Assertion macros used by the sorter's top-level RTL file.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef COCKTAIL_SHAKER_SORTER_MACROS_SVH
`define COCKTAIL_SHAKER_SORTER_MACROS_SVH

`ifndef SYNTHESIS
`define CCS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorter assertion failed");
`define CCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter assertion failed");
`else
`define CCS_ASSERT_ALWAYS(lbl, cond)
`define CCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ccs_pkg.sv =====
// Shared types and constants of the cocktail shaker sorter.
// Used by the controller, the datapath and the top level; depends on nothing.
package ccs_pkg;

    localparam int MAX_ITEMS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SORT_CHK = 12'b0000_0000_0010,
        ST_ROUND    = 12'b0000_0000_0100,
        ST_F_LDW    = 12'b0000_0000_1000,
        ST_F_CMP    = 12'b0000_0001_0000,
        ST_F_END    = 12'b0000_0010_0000,
        ST_B_CHK    = 12'b0000_0100_0000,
        ST_B_LDW    = 12'b0000_1000_0000,
        ST_B_CMP    = 12'b0001_0000_0000,
        ST_B_END    = 12'b0010_0000_0000,
        ST_OUT_CAP  = 12'b0100_0000_0000,
        ST_OUT_WAIT = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic round_start;
        logic f_first;
        logic f_step;
        logic f_end;
        logic b_start;
        logic b_first;
        logic b_step;
        logic b_end;
        logic left_inc;
        logic out_start;
        logic out_cap;
        logic out_next;
        logic clear_count;
    } cmd_t;

    typedef struct packed {
        logic cnt_ge2;
        logic win_open;
        logic swapped;
        logic f_last;
        logic b_last;
        logic out_last;
    } status_t;

endpackage

// ===== rtl/ccs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ccs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ccs_ctrl.sv =====
// Sequencing state machine of the sorter: load, shaker rounds, read-out.
// Depends on ccs_pkg; drives the datapath through cmd_t and reads status_t.
module ccs_ctrl
    import ccs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT_WAIT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = ST_SORT_CHK;
                    end
                end
            end
            ST_SORT_CHK:
            begin
                if (status.cnt_ge2)
                begin
                    cmd.sort_init = 1'b1;
                    state_next    = ST_ROUND;
                end
                else
                begin
                    cmd.out_start = 1'b1;
                    state_next    = ST_OUT_CAP;
                end
            end
            ST_ROUND:
            begin
                if (status.win_open && status.swapped)
                begin
                    cmd.round_start = 1'b1;
                    state_next      = ST_F_LDW;
                end
                else
                begin
                    cmd.out_start = 1'b1;
                    state_next    = ST_OUT_CAP;
                end
            end
            ST_F_LDW:
            begin
                cmd.f_first = 1'b1;
                state_next  = ST_F_CMP;
            end
            ST_F_CMP:
            begin
                cmd.f_step = 1'b1;
                if (status.f_last)
                begin
                    state_next = ST_F_END;
                end
            end
            ST_F_END:
            begin
                cmd.f_end  = 1'b1;
                state_next = ST_B_CHK;
            end
            ST_B_CHK:
            begin
                if (status.win_open)
                begin
                    cmd.b_start = 1'b1;
                    state_next  = ST_B_LDW;
                end
                else
                begin
                    cmd.left_inc = 1'b1;
                    state_next   = ST_ROUND;
                end
            end
            ST_B_LDW:
            begin
                cmd.b_first = 1'b1;
                state_next  = ST_B_CMP;
            end
            ST_B_CMP:
            begin
                cmd.b_step = 1'b1;
                if (status.b_last)
                begin
                    state_next = ST_B_END;
                end
            end
            ST_B_END:
            begin
                cmd.b_end  = 1'b1;
                state_next = ST_ROUND;
            end
            ST_OUT_CAP:
            begin
                cmd.out_cap = 1'b1;
                state_next  = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    if (status.out_last)
                    begin
                        cmd.clear_count = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_CAP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ccs_dp.sv =====
// Datapath of the sorter: value store, window bounds, carried value and compare.
// Depends on ccs_pkg and ccs_ram; controlled by ccs_ctrl through cmd_t.
module ccs_dp
    import ccs_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [VALUE_BITS-1:0] s_value,
    input  logic                  cfg_we,
    input  logic                  cfg_descending,
    output logic [VALUE_BITS-1:0] m_value,
    output logic                  m_last,
    output status_t               status
);

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     left_reg, left_next;
    logic [ADDR_W-1:0]     right_reg, right_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [VALUE_BITS-1:0] carry_reg, carry_next;
    logic                  swapped_reg, swapped_next;
    logic                  descending_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_last_reg;

    logic                  full;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [VALUE_BITS-1:0] cmp_a;
    logic [VALUE_BITS-1:0] cmp_b;
    logic                  swap;

    ccs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full = (count_reg == CNT_W'(MAX_ITEMS));

    // The forward pass carries the lower-index operand, the backward pass the upper one.
    assign cmp_a = cmd.b_step ? ram_rdata : carry_reg;
    assign cmp_b = cmd.b_step ? carry_reg : ram_rdata;
    assign swap  = descending_reg ? ($signed(cmp_a) < $signed(cmp_b))
                                  : ($signed(cmp_a) > $signed(cmp_b));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = carry_reg;
        if (cmd.load)
        begin
            ram_we    = !full;
            ram_waddr = count_reg[ADDR_W-1:0];
            ram_wdata = s_value;
        end
        else if (cmd.f_step || cmd.b_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = swap ? ram_rdata : carry_reg;
        end
        else if (cmd.f_end || cmd.b_end)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        ram_raddr = idx_reg;
        if (cmd.round_start)
        begin
            ram_raddr = left_reg;
        end
        else if (cmd.f_first || cmd.out_next)
        begin
            ram_raddr = idx_reg + ADDR_W'(1);
        end
        else if (cmd.f_step)
        begin
            ram_raddr = idx_reg + ADDR_W'(2);
        end
        else if (cmd.b_start)
        begin
            ram_raddr = right_reg;
        end
        else if (cmd.b_first)
        begin
            ram_raddr = idx_reg - ADDR_W'(1);
        end
        else if (cmd.b_step)
        begin
            ram_raddr = idx_reg - ADDR_W'(2);
        end
        else if (cmd.out_start)
        begin
            ram_raddr = '0;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        idx_next     = idx_reg;
        carry_next   = carry_reg;
        swapped_next = swapped_reg;

        if (cmd.load && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        if (cmd.sort_init)
        begin
            left_next    = '0;
            right_next   = ADDR_W'(count_reg - CNT_W'(1));
            swapped_next = 1'b1;
        end
        if (cmd.round_start)
        begin
            idx_next     = left_reg;
            swapped_next = 1'b0;
        end
        if (cmd.f_first || cmd.b_first)
        begin
            carry_next = ram_rdata;
        end
        if (cmd.f_step || cmd.b_step)
        begin
            carry_next = swap ? carry_reg : ram_rdata;
            if (swap)
            begin
                swapped_next = 1'b1;
            end
        end
        if (cmd.f_step || cmd.out_next)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
        if (cmd.b_step)
        begin
            idx_next = idx_reg - ADDR_W'(1);
        end
        if (cmd.f_end)
        begin
            right_next = right_reg - ADDR_W'(1);
        end
        if (cmd.b_start)
        begin
            idx_next = right_reg;
        end
        if (cmd.b_end || cmd.left_inc)
        begin
            left_next = left_reg + ADDR_W'(1);
        end
        if (cmd.out_start)
        begin
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            idx_reg        <= '0;
            swapped_reg    <= 1'b0;
            descending_reg <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            idx_reg     <= idx_next;
            swapped_reg <= swapped_next;
            if (cfg_we)
            begin
                descending_reg <= cfg_descending;
            end
            if (cmd.out_cap)
            begin
                out_last_reg <= ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.out_cap)
        begin
            out_value_reg <= ram_rdata;
        end
    end

    assign m_value = out_value_reg;
    assign m_last  = out_last_reg;

    assign status.cnt_ge2  = (count_reg >= CNT_W'(2));
    assign status.win_open = (left_reg < right_reg);
    assign status.swapped  = swapped_reg;
    assign status.f_last   = ((idx_reg + ADDR_W'(1)) == right_reg);
    assign status.b_last   = (idx_reg == (left_reg + ADDR_W'(1)));
    assign status.out_last = out_last_reg;

endmodule

// ===== rtl/cocktail_shaker_sorter.sv =====
// Channel  | Signals                          | Carries
// s        | s_tvalid s_tready s_tdata s_tlast | value in, last_item
// m        | m_tvalid m_tready m_tdata m_tlast | sorted_value out, last_out
// cfg      | cfg_valid cfg_ready cfg_data     | descending register
//
// Items load while the sorter is idle. A set of N values is then sorted in shaker
// rounds, one compare-swap per cycle through the store's single read port, and
// sorting stops early when a round makes no swap. Read-out reads each item from the
// store and holds it on the output until taken. The input is not taken from the last
// item until the final sorted item has left. Reset is asynchronous and active low.
`include "cocktail_shaker_sorter_macros.svh"

module cocktail_shaker_sorter
    import ccs_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // value, then zero padding
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // sorted_value, then zero padding
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    cmd_t                  cmd;
    status_t               status;
    logic [VALUE_BITS-1:0] m_value;

    assign cfg_ready = 1'b1;

    ccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ccs_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .s_value        (s_tdata[VALUE_BITS-1:0]),
        .cfg_we         (cfg_valid),
        .cfg_descending (cfg_data),
        .m_value        (m_value),
        .m_last         (m_tlast),
        .status         (status)
    );

    assign m_tdata = TDATA_W'(m_value);

    `CCS_ASSERT_ALWAYS(a_no_load_during_output, !(m_tvalid && s_tready))
    `CCS_ASSERT_ALWAYS(a_single_store_writer, $onehot0({cmd.load, cmd.f_step, cmd.f_end, cmd.b_step, cmd.b_end}))
    `CCS_ASSERT_NEXT(a_idle_after_run, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

endmodule

// ===== dv/shaker_sort_scoreboard_pkg.sv =====
// Scoreboard for the cocktail shaker sorter testbench: predicts each sorted run
// from the values loaded so far and checks the values the block sends back.
// Depends on nothing; the capacity of the store is passed in by the testbench.
package shaker_sort_scoreboard_pkg;

    typedef struct {
        logic [31:0] value;
        logic        last;
    } sorted_entry_t;

    class shaker_sort_scoreboard;
        int unsigned        capacity;
        bit                 descending;
        logic signed [31:0] loaded_q[$];
        sorted_entry_t      expected_q[$];
        sorted_entry_t      arrived_q[$];
        int unsigned        mismatches;
        int unsigned        sets_sorted;
        int unsigned        results_checked;
        int unsigned        items_dropped;

        function new(int unsigned capacity);
            this.capacity   = capacity;
            descending      = 1'b0;
            mismatches      = 0;
            sets_sorted     = 0;
            results_checked = 0;
            items_dropped   = 0;
        endfunction

        function void set_order(bit desc);
            descending = desc;
        endfunction

        function bit goes_after(logic signed [31:0] a, logic signed [31:0] b);
            return descending ? (a < b) : (a > b);
        endfunction

        // Loads one value if the store has room; a last item sorts the stored set into expected results.
        function void note_loaded(logic [31:0] value, logic last, longint unsigned stamp);
            logic signed [31:0] work[$];
            logic signed [31:0] tmp;
            sorted_entry_t      entry;
            int                 lo;
            int                 hi;
            bit                 swapped;
            if (loaded_q.size() < capacity)
            begin
                loaded_q.push_back(value);
            end
            else
            begin
                items_dropped++;
            end
            if (!last)
            begin
                return;
            end
            work = loaded_q;
            loaded_q.delete();
            lo = 0;
            hi = work.size() - 1;
            swapped = 1'b1;
            while (lo < hi && swapped)
            begin
                swapped = 1'b0;
                for (int i = lo; i < hi; i++)
                begin
                    if (goes_after(work[i], work[i + 1]))
                    begin
                        tmp = work[i];
                        work[i] = work[i + 1];
                        work[i + 1] = tmp;
                        swapped = 1'b1;
                    end
                end
                hi--;
                for (int i = hi; i > lo; i--)
                begin
                    if (goes_after(work[i - 1], work[i]))
                    begin
                        tmp = work[i - 1];
                        work[i - 1] = work[i];
                        work[i] = tmp;
                        swapped = 1'b1;
                    end
                end
                lo++;
            end
            foreach (work[k])
            begin
                entry.value = work[k];
                entry.last  = (k == work.size() - 1);
                expected_q.push_back(entry);
            end
            sets_sorted++;
            compare_pending(stamp);
        endfunction

        // Results queue here and are matched against the predictions in arrival order.
        function void check_sorted(logic [31:0] value, logic last, longint unsigned stamp);
            sorted_entry_t entry;
            entry.value = value;
            entry.last  = last;
            arrived_q.push_back(entry);
            compare_pending(stamp);
        endfunction

        function void compare_pending(longint unsigned stamp);
            sorted_entry_t want;
            sorted_entry_t got;
            while (expected_q.size() != 0 && arrived_q.size() != 0)
            begin
                want = expected_q.pop_front();
                got  = arrived_q.pop_front();
                results_checked++;
                if (got.value !== want.value)
                begin
                    mismatches++;
                    $display("%0d ns: sorted_value expected %0d got %0d", stamp,
                             $signed(want.value), $signed(got.value));
                end
                if (got.last !== want.last)
                begin
                    mismatches++;
                    $display("%0d ns: last_out expected %0b got %0b", stamp, want.last, got.last);
                end
            end
        endfunction

        function bit all_matched();
            return expected_q.size() == 0 && arrived_q.size() == 0 && loaded_q.size() == 0;
        endfunction

        function void report_leftovers(longint unsigned stamp);
            if (expected_q.size() != 0)
            begin
                mismatches++;
                $display("%0d ns: %0d sorted values never arrived, first expected %0d", stamp,
                         expected_q.size(), $signed(expected_q[0].value));
            end
            if (arrived_q.size() != 0)
            begin
                mismatches++;
                $display("%0d ns: %0d sorted values arrived unexpected, first got %0d", stamp,
                         arrived_q.size(), $signed(arrived_q[0].value));
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_cocktail_shaker_sorter.sv =====
// Top-level testbench of cocktail_shaker_sorter: directed and random sets in both
// orders, random idling on both streams and one long output stall.
// Depends on ccs_pkg, shaker_sort_scoreboard_pkg and the sorter RTL.
module tb_cocktail_shaker_sorter;
    timeunit 1ns;
    timeprecision 1ps;

    import ccs_pkg::*;
    import shaker_sort_scoreboard_pkg::*;

    localparam int CAPACITY      = MAX_ITEMS_DEF;
    localparam int VW            = VALUE_BITS_DEF;
    localparam bit ORDER_ASCENDING  = 1'b0;
    localparam bit ORDER_DESCENDING = 1'b1;
    localparam int IDLE_PERCENT  = 11;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_CYCLES  = 6000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [VW-1:0] VALUE_MIN = {1'b1, {(VW - 1){1'b0}}};
    localparam logic [VW-1:0] VALUE_MAX = {1'b0, {(VW - 1){1'b1}}};

    typedef enum int {
        PAT_FULL,
        PAT_NARROW,
        PAT_EXTREME,
        PAT_RISING,
        PAT_FALLING
    } value_pattern_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [VW-1:0] s_tdata   = '0;
    logic          s_tlast   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [VW-1:0] m_tdata;
    logic          m_tlast;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic          cfg_data  = 1'b0;

    bit          steady_flow = 1'b0;
    bit          stall_req   = 1'b0;
    bit          stall_taken = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;

    shaker_sort_scoreboard sort_board = new(CAPACITY);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cocktail_shaker_sorter #(
        .MAX_ITEMS  (CAPACITY),
        .VALUE_BITS (VW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // value
        .s_tlast   (s_tlast),    // last_item
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // sorted_value
        .m_tlast   (m_tlast),    // last_out
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // descending
    );

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sort_board.check_sorted(m_tdata, m_tlast, $time);
        end
        m_tready <= (stall_left == 0) && (steady_flow || $urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_req && !stall_taken)
        begin
            stall_left  <= STALL_CYCLES;
            stall_taken <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cocktail_shaker_sorter verification failed");
            $finish;
        end
    end

    task automatic send_value(input logic [VW-1:0] value, input logic last);
        if (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sort_board.note_loaded(value, last, $time);
        items_sent++;
    endtask

    task automatic send_set(input int n, input value_pattern_t pattern);
        logic [VW-1:0] v;
        int            base;
        int            stride;
        base   = int'($urandom_range(2000)) - 1000;
        stride = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            case (pattern)
                PAT_FULL:    v = $urandom;
                PAT_NARROW:  v = VW'(int'($urandom_range(8)) - 4);
                PAT_EXTREME:
                begin
                    case ($urandom_range(3))
                        0:       v = VALUE_MIN;
                        1:       v = VALUE_MAX;
                        2:       v = '0;
                        default: v = '1;
                    endcase
                end
                PAT_RISING:  v = VW'(base + i * stride);
                default:     v = VW'(base - i * stride);
            endcase
            send_value(v, i == n - 1);
        end
    endtask

    task automatic write_order(input logic desc);
        cfg_valid <= 1'b1;
        cfg_data  <= desc;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sort_board.set_order(desc);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (!sort_board.all_matched());
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input logic order, input int lead_items, input int small_items,
                                input bit hold_output);
        int loaded;
        int n;
        settle();
        write_order(order);
        if (hold_output)
        begin
            stall_req <= 1'b1;
        end
        if (lead_items > 0)
        begin
            send_set(lead_items, value_pattern_t'($urandom_range(PAT_FALLING)));
        end
        loaded = 0;
        while (loaded < small_items)
        begin
            n = $urandom_range(16, 1);
            send_set(n, value_pattern_t'($urandom_range(PAT_FALLING)));
            loaded += n;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_order(ORDER_ASCENDING);

        // A set of one value needs no sorting at all.
        send_value(VALUE_MIN, 1'b1);
        send_value(VALUE_MAX, 1'b0);
        send_value(VALUE_MIN, 1'b0);
        send_value('0, 1'b0);
        send_value('1, 1'b0);
        send_value(32'h5555_5555, 1'b0);
        send_value(32'hAAAA_AAAA, 1'b0);
        send_value(VALUE_MAX, 1'b1);
        send_value(32'd5, 1'b0);
        send_value(32'd5, 1'b1);

        settle();
        write_order(ORDER_DESCENDING);
        send_value(32'd1, 1'b0);
        send_value(VALUE_MIN, 1'b0);
        send_value('1, 1'b0);
        send_value(VALUE_MAX, 1'b0);
        send_value('0, 1'b0);
        send_value(VALUE_MIN, 1'b1);
        // Already in order, so the first round makes no swap and sorting stops.
        send_value(32'd3, 1'b0);
        send_value(32'd2, 1'b0);
        send_value(32'd1, 1'b1);

        random_phase(ORDER_ASCENDING, 0, 80, 1'b0);
        random_phase(ORDER_DESCENDING, CAPACITY, 40, 1'b1);
        random_phase(ORDER_ASCENDING, CAPACITY + int'($urandom_range(4, 1)), 40, 1'b0);
        steady_flow <= 1'b1;
        random_phase(ORDER_DESCENDING, 0, 80, 1'b0);
        settle();
        steady_flow <= 1'b0;

        sort_board.report_leftovers($time);
        $display("Sent %0d items in %0d sets, both orders, %0d dropped at a full store.",
                 items_sent, sort_board.sets_sorted, sort_board.items_dropped);
        $display("Checked %0d sorted values, with one long output stall in the run.",
                 sort_board.results_checked);
        if (sort_board.mismatches == 0)
        begin
            $display("cocktail_shaker_sorter verification clean");
        end
        else
        begin
            $display("cocktail_shaker_sorter verification failed");
        end
        $finish;
    end

endmodule

// ===== cocktail_shaker_sorter.f =====
+incdir+rtl
rtl/ccs_pkg.sv
rtl/ccs_ram.sv
rtl/ccs_ctrl.sv
rtl/ccs_dp.sv
rtl/cocktail_shaker_sorter.sv
dv/shaker_sort_scoreboard_pkg.sv
dv/tb_cocktail_shaker_sorter.sv
